/* sv/piecewise_linear_rgba_transfer_lookup_defines.svh */
// Assertion macros used by the checker file.
`ifndef PIECEWISE_LINEAR_RGBA_TRANSFER_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_RGBA_TRANSFER_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLRGBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plrgba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLRGBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plrgba assertion failed");

`endif

/* sv/plrgba_pkg.sv */
package plrgba_pkg;

    localparam int unsigned MAX_POINTS_DEF = 16;
    localparam int unsigned CFG_W          = 5;
    localparam int unsigned IDX_W          = 4;
    localparam int unsigned VAL_W          = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] pos;
        logic [VAL_W-1:0] alpha;
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
    } t_point;

    localparam int unsigned PT_W = $bits(t_point);

endpackage

/* sv/plrgba_req_if.sv */
interface plrgba_req_if;
    import plrgba_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] point_index;
    logic [VAL_W-1:0] point_position;
    logic [VAL_W-1:0] point_alpha;
    logic [VAL_W-1:0] point_red;
    logic [VAL_W-1:0] point_green;
    logic [VAL_W-1:0] point_blue;
    logic [VAL_W-1:0] sample_value;

    modport source (
        output valid, action, point_index, point_position, point_alpha,
               point_red, point_green, point_blue, sample_value,
        input  ready
    );

    modport sink (
        input  valid, action, point_index, point_position, point_alpha,
               point_red, point_green, point_blue, sample_value,
        output ready
    );
endinterface

/* sv/plrgba_res_if.sv */
interface plrgba_res_if;
    import plrgba_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] red_out;
    logic [VAL_W-1:0] green_out;
    logic [VAL_W-1:0] blue_out;
    logic [VAL_W-1:0] alpha_out;
    logic             covered;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, covered,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, covered,
        output ready
    );
endinterface

/* sv/plrgba_ram.sv */
module plrgba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/piecewise_linear_rgba_transfer_lookup.sv */
// Piecewise-linear RGBA transfer function.
// i_req carries write beats (action = write: store one control point in a slot)
// and lookup beats (action = lookup: map sample_value to a color). o_res gives
// one beat per lookup and none per write. i_cfg_we/i_cfg_data set the number of
// control points in use (n, clamped to 2..MAX_POINTS); write it only while idle.
// A write is stored while the block stays idle, so i_req stays ready.
// A lookup reads the point memory one slot per cycle through the single read
// port, then forms the products in S_MUL and runs the shift-subtract division
// of all four channels in parallel in S_DIV; a lookup with no covering segment
// skips the division. The result becomes valid and i_req is ready again in the
// same cycle, so the block takes no new item until the previous lookup is done.
// A lookup of sample zero returns point 0 straight from slot 0, without walking the other slots.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a second finished lookup holds its result
// internally until the output register frees up, with i_req not ready.
// Reset clears the control state and sets n to 2; the point memory is not
// cleared and slots must be written before they are used.
module piecewise_linear_rgba_transfer_lookup #(
    parameter int unsigned MAX_POINTS = plrgba_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [plrgba_pkg::CFG_W-1:0] i_cfg_data,
    plrgba_req_if.sink                   i_req,
    plrgba_res_if.source                 o_res
);
    import plrgba_pkg::*;

    localparam int unsigned AW     = $clog2(MAX_POINTS);
    localparam int unsigned CW     = $clog2(MAX_POINTS + 1);
    localparam int unsigned NUM_CH = 4;
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;
    localparam int unsigned CH_ALPHA = 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CFG_W-1:0] r_pts;
    logic [VAL_W-1:0] r_s;
    logic             r_zero;
    logic             r_first;
    logic             r_hit;
    logic [CW-1:0]    r_cnt;
    t_point           r_prev;
    t_point           r_p;
    t_point           r_q;
    logic [VAL_W:0]   r_d2;
    logic [2:0]       r_k;
    logic [16:0]      r_rem [NUM_CH];
    logic [VAL_W-1:0] r_quo [NUM_CH];
    logic             r_cov;
    logic             r_ov;
    logic [VAL_W-1:0] r_out_ch [NUM_CH];
    logic             r_out_cov;

    logic             acc;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [PT_W-1:0]  rd_data;
    t_point           cur;
    t_point           wr_pt;
    logic [7:0]       pts_ext;
    logic [7:0]       n_clamp;
    logic [CW-1:0]    n_act;
    logic             seg_hit;
    logic             out_free;

    logic [VAL_W-1:0]   seg_d;
    logic [VAL_W-1:0]   seg_t;
    logic [VAL_W-1:0]   v1 [NUM_CH];
    logic [VAL_W-1:0]   v2 [NUM_CH];
    logic signed [8:0]  diff [NUM_CH];
    logic signed [17:0] prod [NUM_CH];
    logic [15:0]        v1d [NUM_CH];
    logic signed [18:0] tot [NUM_CH];
    logic [16:0]        div_sh;
    logic               ge [NUM_CH];

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign wr_en       = acc && (i_req.action == ACT_WRITE)
                         && (8'(i_req.point_index) < 8'(MAX_POINTS));
    assign out_free    = !r_ov || o_res.ready;

    assign wr_pt.pos   = i_req.point_position;
    assign wr_pt.alpha = i_req.point_alpha;
    assign wr_pt.red   = i_req.point_red;
    assign wr_pt.green = i_req.point_green;
    assign wr_pt.blue  = i_req.point_blue;

    // read slot 0 on acceptance, then walk the slots during the scan
    assign rd_addr = (r_state == S_SCAN) ? r_cnt[AW-1:0] : '0;
    assign cur     = t_point'(rd_data);

    plrgba_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_req.point_index)),
        .i_wdata (wr_pt),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        pts_ext = 8'(r_pts);
        if (pts_ext < 8'd2) begin
            n_clamp = 8'd2;
        end else if (pts_ext > 8'(MAX_POINTS)) begin
            n_clamp = 8'(MAX_POINTS);
        end else begin
            n_clamp = pts_ext;
        end
        n_act = CW'(n_clamp);
    end

    assign seg_hit = (r_prev.pos < r_s) && (r_s <= cur.pos);

    assign seg_d = r_q.pos - r_p.pos;
    assign seg_t = r_s - r_p.pos;
    assign v1[CH_RED]   = r_p.red;
    assign v1[CH_GREEN] = r_p.green;
    assign v1[CH_BLUE]  = r_p.blue;
    assign v1[CH_ALPHA] = r_p.alpha;
    assign v2[CH_RED]   = r_q.red;
    assign v2[CH_GREEN] = r_q.green;
    assign v2[CH_BLUE]  = r_q.blue;
    assign v2[CH_ALPHA] = r_q.alpha;

    // total = 2*v1*d + 2*(v2-v1)*t + d, never negative since 0 <= t <= d
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            diff[c] = $signed({1'b0, v2[c]}) - $signed({1'b0, v1[c]});
            prod[c] = diff[c] * $signed({1'b0, seg_t});
            v1d[c]  = 16'(v1[c]) * 16'(seg_d);
            tot[c]  = $signed({2'b0, v1d[c], 1'b0}) + $signed({prod[c], 1'b0})
                      + $signed({11'b0, seg_d});
        end
    end

    // restoring division by 2*d, one quotient bit per cycle, quotient < 256
    assign div_sh = {8'b0, r_d2} << r_k;
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            ge[c] = (r_rem[c] >= div_sh);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && (i_req.action == ACT_LOOKUP)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_first && r_zero) begin
                    n_state = S_DONE;
                end else if (!r_first && (r_cnt == n_act)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = r_hit ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (r_k == 3'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pts   <= CFG_RESET;
            r_ov    <= 1'b0;
            r_first <= 1'b0;
            r_hit   <= 1'b0;
            r_zero  <= 1'b0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_cov   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pts <= i_cfg_data;
            end
            // a finished lookup refills the output register as it drains
            if ((r_state == S_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (acc && (i_req.action == ACT_LOOKUP)) begin
                        r_s     <= i_req.sample_value;
                        r_zero  <= (i_req.sample_value == '0);
                        r_first <= 1'b1;
                        r_hit   <= 1'b0;
                        r_cnt   <= CW'(1);
                    end
                end
                S_SCAN: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_first <= 1'b0;
                    r_prev  <= cur;
                    if (r_first && r_zero) begin
                        r_quo[CH_RED]   <= cur.red;
                        r_quo[CH_GREEN] <= cur.green;
                        r_quo[CH_BLUE]  <= cur.blue;
                        r_quo[CH_ALPHA] <= cur.alpha;
                        r_cov           <= 1'b1;
                    end else if (!r_first && seg_hit) begin
                        // later segments override earlier ones
                        r_p   <= r_prev;
                        r_q   <= cur;
                        r_hit <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_d2 <= {seg_d, 1'b0};
                    r_k  <= 3'd7;
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_rem[c] <= tot[c][16:0];
                        r_quo[c] <= '0;
                    end
                    r_cov <= r_hit;
                end
                S_DIV: begin
                    r_k <= r_k - 3'd1;
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (ge[c]) begin
                            r_rem[c] <= r_rem[c] - div_sh;
                        end
                        r_quo[c] <= {r_quo[c][VAL_W-2:0], ge[c]};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_out_ch[c] <= r_quo[c];
            end
            r_out_cov <= r_cov;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.red_out   = r_out_ch[CH_RED];
    assign o_res.green_out = r_out_ch[CH_GREEN];
    assign o_res.blue_out  = r_out_ch[CH_BLUE];
    assign o_res.alpha_out = r_out_ch[CH_ALPHA];
    assign o_res.covered   = r_out_cov;
endmodule

/* sv/plrgba_checker.sv */
`include "piecewise_linear_rgba_transfer_lookup_defines.svh"

module plrgba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_action,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [plrgba_pkg::VAL_W-1:0] i_red,
    input logic [plrgba_pkg::VAL_W-1:0] i_green,
    input logic [plrgba_pkg::VAL_W-1:0] i_blue,
    input logic [plrgba_pkg::VAL_W-1:0] i_alpha,
    input logic                         i_covered
);
    import plrgba_pkg::*;

    `PLRGBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    `PLRGBA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_alpha) && $stable(i_covered))

    // an accepted lookup beat makes the block busy, so i_req is not ready once it is taken
    `PLRGBA_ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_action == ACT_LOOKUP), !i_in_ready)

    // uncovered samples come out black and transparent
    `PLRGBA_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, i_out_valid && !i_covered, (i_red == '0) && (i_green == '0) && (i_blue == '0) && (i_alpha == '0))
endmodule

bind piecewise_linear_rgba_transfer_lookup plrgba_checker u_plrgba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_action (i_req.action),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_red       (o_res.red_out),
    .i_green     (o_res.green_out),
    .i_blue      (o_res.blue_out),
    .i_alpha     (o_res.alpha_out),
    .i_covered   (o_res.covered)
);
